/* rtl/acm_pkg.sv */
// Types, constants and the calibration ROM of the ADC trimmed-mean core.
// Used by acm_div, acm_ctrl, acm_dp and adc_calibrated_trimmed_mean_core.
package acm_pkg;

   localparam int VAL_W    = 11;   // history entry and result width
   localparam int DIV_W    = 17;   // constant divide unit operand width
   localparam int ROM_ROWS = 6;
   localparam int CAL_LEN  = 17;
   localparam int SCALE_MUL = 1000;
   localparam int SCALE_SHIFT = 12;
   localparam int CAL_DIVISOR = 100;
   // Reciprocal multiply: q = (x * ceil(2^24 / d)) >> 24, exact for 17-bit x, d <= 100.
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 25;
   localparam int CAL_RECIP   = (2**RECIP_SHIFT + CAL_DIVISOR - 1) / CAL_DIVISOR;

   localparam logic [9:0] CAL_BP [ROM_ROWS][CAL_LEN] = '{
      '{10'd7, 10'd37, 10'd59, 10'd81, 10'd104, 10'd126, 10'd149, 10'd196, 10'd293,
        10'd383, 10'd477, 10'd571, 10'd658, 10'd758, 10'd849, 10'd926, 10'd0},
      '{10'd7, 10'd37, 10'd59, 10'd81, 10'd104, 10'd126, 10'd149, 10'd196, 10'd293,
        10'd383, 10'd477, 10'd571, 10'd658, 10'd758, 10'd849, 10'd926, 10'd0},
      '{10'd7, 10'd37, 10'd59, 10'd81, 10'd104, 10'd126, 10'd149, 10'd196, 10'd293,
        10'd383, 10'd477, 10'd571, 10'd658, 10'd758, 10'd849, 10'd926, 10'd0},
      '{10'd7, 10'd37, 10'd59, 10'd81, 10'd104, 10'd126, 10'd149, 10'd196, 10'd293,
        10'd383, 10'd477, 10'd571, 10'd658, 10'd758, 10'd849, 10'd926, 10'd0},
      '{default: 10'd0},
      '{default: 10'd0}
   };

   localparam logic [6:0] CAL_FAC [ROM_ROWS][CAL_LEN] = '{
      '{7'd0, 7'd68, 7'd85, 7'd93, 7'd96, 7'd99, 7'd101, 7'd102, 7'd102,
        7'd104, 7'd105, 7'd105, 7'd106, 7'd106, 7'd106, 7'd108, 7'd108},
      '{7'd0, 7'd68, 7'd88, 7'd93, 7'd96, 7'd99, 7'd101, 7'd102, 7'd102,
        7'd104, 7'd105, 7'd105, 7'd106, 7'd106, 7'd106, 7'd108, 7'd108},
      '{7'd0, 7'd68, 7'd85, 7'd93, 7'd96, 7'd99, 7'd101, 7'd102, 7'd102,
        7'd104, 7'd105, 7'd105, 7'd106, 7'd106, 7'd106, 7'd108, 7'd108},
      '{7'd0, 7'd68, 7'd83, 7'd93, 7'd96, 7'd99, 7'd101, 7'd102, 7'd102,
        7'd104, 7'd105, 7'd105, 7'd106, 7'd106, 7'd106, 7'd108, 7'd108},
      '{7'd48, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
      '{7'd48, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0}
   };

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_SCALE, ST_CAL, ST_SDIV_GO, ST_SDIV_WAIT,
      ST_LOAD, ST_RANK, ST_RDIV_GO, ST_RDIV_WAIT, ST_OUT
   } acm_state_type;

   typedef struct packed {
      logic capture;
      logic scale;
      logic cal;
      logic div_start;
      logic div_sel_sum;
      logic hist_write;
      logic cnt_clear;
      logic load_step;
      logic rank_step;
      logic res_load;
      logic res_zero;
   } acm_cmd_type;

   typedef struct packed {
      logic is_read;
      logic read_ok;
      logic take;
      logic load_last;
      logic rank_last;
      logic div_done;
   } acm_stat_type;

   // Segment factor: first segment whose breakpoint is the end marker or
   // whose next breakpoint lies above the value; else the last entry.
   function automatic logic [6:0] calib_factor(input logic [2:0] row,
                                               input logic [9:0] v);
      logic [6:0] fac;
      logic       found;
      logic [2:0] r;
      fac   = CAL_FAC[0][CAL_LEN-1];
      found = 1'b0;
      r     = (row < 3'(ROM_ROWS)) ? row : 3'd0;
      fac   = CAL_FAC[r][CAL_LEN-1];
      for (int i = 0; i < CAL_LEN; i++) begin
         if (!found) begin
            if (CAL_BP[r][i] == 10'd0) begin
               fac   = CAL_FAC[r][i];
               found = 1'b1;
            end else if (i + 1 < CAL_LEN) begin
               if (v < CAL_BP[r][i+1]) begin
                  fac   = CAL_FAC[r][i];
                  found = 1'b1;
               end
            end
         end
      end
      return fac;
   endfunction

endpackage

/* rtl/acm_div.sv */
// Divide by a constant through a reciprocal multiply; the quotient is registered in the cycle after start.
// Depends on acm_pkg for the operand and reciprocal widths.
module acm_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [acm_pkg::DIV_W-1:0]   dividend,
   input  logic [acm_pkg::RECIP_W-1:0] recip,
   output logic [acm_pkg::DIV_W-1:0]   quotient,
   output logic                        done
);
   import acm_pkg::*;

   localparam int PW = DIV_W + RECIP_W;

   logic [PW-1:0]    prod;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic             done_ff, done_in;

   assign prod = PW'(dividend) * PW'(recip);

   always_comb begin
      quo_in  = start ? prod[RECIP_SHIFT +: DIV_W] : quo_ff;
      done_in = start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* rtl/acm_ctrl.sv */
// Sequencer of the trimmed-mean core: decodes a word and steps the datapath.
// Depends on acm_pkg for state, command and status types.
module acm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  acm_pkg::acm_stat_type stat,
   output acm_pkg::acm_cmd_type  cmd,
   output logic                  busy,
   output logic                  strobe
);
   import acm_pkg::*;

   acm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      strobe   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_read) begin
               if (stat.read_ok) begin
                  cmd.cnt_clear = 1'b1;
                  state_in      = ST_LOAD;
               end else begin
                  cmd.res_zero = 1'b1;
                  state_in     = ST_OUT;
               end
            end else if (stat.take) begin
               state_in = ST_SCALE;
            end else begin
               state_in = ST_IDLE;   // drop the word
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_CAL;
         end
         ST_CAL: begin
            cmd.cal  = 1'b1;
            state_in = ST_SDIV_GO;
         end
         ST_SDIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_SDIV_WAIT;
         end
         ST_SDIV_WAIT: begin
            if (stat.div_done) begin
               cmd.hist_write = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.load_step = 1'b1;
            if (stat.load_last) begin
               cmd.cnt_clear = 1'b1;
               state_in      = ST_RANK;
            end
         end
         ST_RANK: begin
            cmd.rank_step = 1'b1;
            if (stat.rank_last) begin
               state_in = ST_RDIV_GO;
            end
         end
         ST_RDIV_GO: begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_sum = 1'b1;
            state_in        = ST_RDIV_WAIT;
         end
         ST_RDIV_WAIT: begin
            if (stat.div_done) begin
               cmd.res_load = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            strobe   = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* rtl/acm_dp.sv */
// Datapath: scaling, calibration, history memory, rank-and-sum trim.
// Depends on acm_pkg and acm_div.
module acm_dp #(
   parameter int HISTORY_DEPTH = 9,
   parameter int TRIM_COUNT    = 3,
   parameter int CHANNELS      = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  acm_pkg::acm_cmd_type   cmd,
   output acm_pkg::acm_stat_type  stat,
   input  logic                   req_command,
   input  logic [2:0]             req_channel,
   input  logic                   req_sample_done,
   input  logic [11:0]            req_sample_raw,
   input  logic                   csr_we,
   input  logic [5:0]             csr_data,
   output logic [acm_pkg::VAL_W-1:0] rsp_filtered_value
);
   import acm_pkg::*;

   localparam int DEPTH   = CHANNELS * HISTORY_DEPTH;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int IDX_W   = $clog2(HISTORY_DEPTH);
   localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DIVISOR = (2 * TRIM_COUNT < HISTORY_DEPTH) ?
                            HISTORY_DEPTH - 2 * TRIM_COUNT : 1;
   localparam int SUM_RECIP = (2**RECIP_SHIFT + DIVISOR - 1) / DIVISOR;

   logic [5:0]        mask_ff;
   logic              cmd_ff;
   logic [2:0]        ch_ff;
   logic              done_ff;
   logic [11:0]       raw_ff;
   logic [9:0]        v_ff;
   logic [DIV_W-1:0]  prod_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DIV_W-1:0]  sum_ff;
   logic [VAL_W-1:0]  res_ff;
   logic [VAL_W-1:0]  mem_q_ff;
   logic [VAL_W-1:0]  buf_ff [HISTORY_DEPTH];
   logic [IDX_W-1:0]  ptr_ff [CHANNELS];
   logic [CNT_W-1:0]  fill_ff [CHANNELS];
   logic [VAL_W-1:0]  hist_mem [DEPTH];

   logic [CH_W-1:0]   chi;
   logic [ADDR_W-1:0] base, rd_addr, wr_addr;
   logic [VAL_W-1:0]  cur;
   logic [CNT_W-1:0]  rank;
   logic              keep;
   logic [DIV_W-1:0]  quo;
   logic              div_done;
   logic [21:0]       scaled;
   logic [IDX_W-1:0]  ld_idx;

   assign chi     = ch_ff[CH_W-1:0];
   assign base    = ADDR_W'(chi) * ADDR_W'(HISTORY_DEPTH);
   assign rd_addr = base + ADDR_W'(cnt_ff);
   assign wr_addr = base + ADDR_W'(ptr_ff[chi]);
   assign cur     = buf_ff[cnt_ff[IDX_W-1:0]];
   assign ld_idx  = IDX_W'(cnt_ff - CNT_W'(1));
   assign scaled  = (22'(raw_ff) * 22'(SCALE_MUL)) >> SCALE_SHIFT;

   // Rank with ties broken by position; keep the middle band.
   always_comb begin
      rank = '0;
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
         if (buf_ff[j] < cur || (buf_ff[j] == cur && j < int'(cnt_ff))) begin
            rank = rank + CNT_W'(1);
         end
      end
      keep = (int'(rank) >= TRIM_COUNT) && (int'(rank) < HISTORY_DEPTH - TRIM_COUNT);
   end

   always_comb begin
      stat.is_read   = cmd_ff;
      stat.read_ok   = ({1'b0, ch_ff} < 4'(CHANNELS));
      stat.take      = !cmd_ff && done_ff && ({1'b0, ch_ff} < 4'(CHANNELS)) &&
                       ({1'b0, ch_ff} < 4'(ROM_ROWS)) && mask_ff[ch_ff];
      stat.load_last = (cnt_ff == CNT_W'(HISTORY_DEPTH));
      stat.rank_last = (cnt_ff == CNT_W'(HISTORY_DEPTH - 1));
      stat.div_done  = div_done;
   end

   acm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cmd.div_sel_sum ? sum_ff : prod_ff),
      .recip    (cmd.div_sel_sum ? RECIP_W'(SUM_RECIP) : RECIP_W'(CAL_RECIP)),
      .quotient (quo),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      mem_q_ff <= hist_mem[rd_addr];
      if (cmd.hist_write) begin
         hist_mem[wr_addr] <= quo[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         cnt_ff  <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            ptr_ff[c]  <= '0;
            fill_ff[c] <= '0;
         end
      end else begin
         if (csr_we) begin
            mask_ff <= csr_data;
         end
         if (cmd.cnt_clear) begin
            cnt_ff <= '0;
         end else if (cmd.load_step || cmd.rank_step) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.hist_write) begin
            ptr_ff[chi] <= (ptr_ff[chi] == IDX_W'(HISTORY_DEPTH - 1)) ?
                           '0 : ptr_ff[chi] + IDX_W'(1);
            if (fill_ff[chi] != CNT_W'(HISTORY_DEPTH)) begin
               fill_ff[chi] <= fill_ff[chi] + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_command;
         ch_ff   <= req_channel;
         done_ff <= req_sample_done;
         raw_ff  <= req_sample_raw;
      end
      if (cmd.scale) begin
         v_ff <= scaled[9:0];
      end
      if (cmd.cal) begin
         prod_ff <= DIV_W'(v_ff) * DIV_W'(calib_factor(ch_ff, v_ff));
      end
      // The read is registered, so each entry is stored at the index before the count; never-written slots read zero.
      if (cmd.load_step && cnt_ff != '0) begin
         buf_ff[ld_idx] <= (cnt_ff <= fill_ff[chi]) ? mem_q_ff : '0;
      end
      if (cmd.cnt_clear) begin
         sum_ff <= '0;
      end else if (cmd.rank_step && keep) begin
         sum_ff <= sum_ff + DIV_W'(cur);
      end
      if (cmd.res_zero) begin
         res_ff <= '0;
      end else if (cmd.res_load) begin
         res_ff <= quo[VAL_W-1:0];
      end
   end

   assign rsp_filtered_value = res_ff;

endmodule

/* rtl/adc_calibrated_trimmed_mean_core.sv */
// Top level of the calibrated trimmed-mean ADC core.
// Depends on acm_pkg, acm_ctrl, acm_dp (and acm_div through acm_dp).
//
//   channel   ports                                     handshake
//   request   req_command req_channel req_sample_done   start, taken when busy is low
//             req_sample_raw
//   response  rsp_filtered_value                        rsp_strobe, one cycle
//   control   csr_channel_mask                          csr_valid / csr_ready
//
// A taken sample word holds busy through decode, scale, calibrate, divide and write; a
// dropped sample only through decode. A read holds busy through decode, load, rank,
// divide and output, with one memory read per cycle and one rank per cycle; the result
// is strobed in the output state, after which busy falls. A read of a channel out of
// range goes from decode straight to the output state, where it is strobed. Reset is
// synchronous; fill counts make the history read as zero until written. The response
// cannot be stalled; the next word is taken once busy falls.
module adc_calibrated_trimmed_mean_core #(
   parameter int HISTORY_DEPTH = 9,
   parameter int TRIM_COUNT    = 3,
   parameter int CHANNELS      = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [2:0]  req_channel,
   input  logic        req_sample_done,
   input  logic [11:0] req_sample_raw,
   output logic        rsp_strobe,
   output logic [10:0] rsp_filtered_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_channel_mask
);
   import acm_pkg::*;

   acm_cmd_type  cmd;
   acm_stat_type stat;

   assign csr_ready = 1'b1;

   acm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy),
      .strobe (rsp_strobe)
   );

   acm_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .TRIM_COUNT    (TRIM_COUNT),
      .CHANNELS      (CHANNELS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_command        (req_command),
      .req_channel        (req_channel),
      .req_sample_done    (req_sample_done),
      .req_sample_raw     (req_sample_raw),
      .csr_we             (csr_valid & csr_ready),
      .csr_data           (csr_channel_mask),
      .rsp_filtered_value (rsp_filtered_value)
   );

endmodule

/* test/tb_adc_calibrated_trimmed_mean_core.sv */
// Testbench for adc_calibrated_trimmed_mean_core: directed and random sample and read words,
// with a behavioural predictor of the history rows. Depends on the core and acm_pkg.
`timescale 1ns / 100ps

module tb_adc_calibrated_trimmed_mean_core;

   localparam int NCHAN = 6;
   localparam int DEPTH = 9;
   localparam int TRIM  = 3;
   localparam bit CMD_SAMPLE = 1'b0;
   localparam bit CMD_READ   = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = 1'b0;
   logic [2:0]  req_channel = '0;
   logic        req_sample_done = 1'b0;
   logic [11:0] req_sample_raw = '0;
   logic        rsp_strobe;
   logic [10:0] rsp_filtered_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_channel_mask = '0;

   adc_calibrated_trimmed_mean_core dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [5:0]  mask_model;
   logic [10:0] hist_model [NCHAN][DEPTH];
   logic [10:0] mean_q [$];
   int          mismatches = 0;
   int          n_reads = 0;
   int          n_samples = 0;
   int          n_results = 0;
   bit          no_idle = 1'b0;

   localparam int BREAK_PT [16] = '{7, 37, 59, 81, 104, 126, 149, 196, 293, 383, 477, 571,
                                    658, 758, 849, 926};
   localparam int GAIN [16] = '{0, 68, 85, 93, 96, 99, 101, 102, 102, 104, 105, 105,
                                106, 106, 106, 108};

   function automatic int segment_gain(input int ch, input int v);
      int g;
      if (ch >= 4) return 48;
      for (int i = 0; i < 15; i++) begin
         if (v < BREAK_PT[i+1]) begin
            g = GAIN[i];
            // the third segment differs per channel
            if (i == 2) g = (ch == 1) ? 88 : (ch == 3) ? 83 : 85;
            return g;
         end
      end
      return 108;
   endfunction

   function automatic logic [10:0] trimmed_mean_of(input int ch);
      int vals [$];
      int sum;
      sum = 0;
      for (int i = 0; i < DEPTH; i++) vals.push_back(hist_model[ch][i]);
      vals.sort();
      for (int i = TRIM; i < DEPTH - TRIM; i++) sum += vals[i];
      return 11'(sum / (DEPTH - 2 * TRIM));
   endfunction

   task automatic apply_word(input bit cmd, input int ch, input bit done, input int raw);
      int scaled;
      int v;
      if (cmd == CMD_READ) begin
         mean_q.push_back(ch < NCHAN ? trimmed_mean_of(ch) : 11'd0);
         n_reads++;
         return;
      end
      n_samples++;
      if (ch >= NCHAN || !done || !mask_model[ch]) return;
      scaled = (raw * 1000) / 4096;
      v = (scaled * segment_gain(ch, scaled)) / 100;
      for (int i = 0; i < DEPTH - 1; i++) hist_model[ch][i] = hist_model[ch][i+1];
      hist_model[ch][DEPTH-1] = 11'(v);
   endtask

   // send one word; start is left high, the caller or the next idle lowers it
   task automatic send_word(input bit cmd, input int ch, input bit done, input int raw);
      @(negedge clock);
      if (!no_idle && $urandom_range(99) < 9) begin
         start = 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      start = 1'b1;
      req_command = cmd;
      req_channel = 3'(ch);
      req_sample_done = done;
      req_sample_raw = 12'(raw);
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      apply_word(cmd, ch, done, raw);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (mean_q.size() != 0) @(posedge clock);
      // a sample has no result; let it finish
      repeat (60) @(posedge clock);
   endtask

   task automatic write_mask(input logic [5:0] m);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_channel_mask = m;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      mask_model = m;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         n_results++;
         if (mean_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("filtered_value: expected no result, got %0d", rsp_filtered_value);
         end else begin
            logic [10:0] want;
            want = mean_q.pop_front();
            if (want !== rsp_filtered_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("filtered_value: expected %0d, got %0d", want, rsp_filtered_value);
            end
         end
      end
   end

   task automatic test_reset_state();
      for (int c = 0; c < 8; c++) send_word(CMD_READ, c, 1'b1, 0);
      send_word(CMD_SAMPLE, 0, 1'b1, 4095);   // masked off: dropped
      send_word(CMD_READ, 0, 1'b0, 4095);
   endtask

   task automatic test_extremes();
      write_mask(6'h3F);
      send_word(CMD_SAMPLE, 0, 1'b0, 4095);    // done clear
      send_word(CMD_SAMPLE, 6, 1'b1, 4095);    // no such channel
      send_word(CMD_SAMPLE, 7, 1'b1, 4095);
      for (int c = 0; c < NCHAN; c++) begin
         send_word(CMD_SAMPLE, c, 1'b1, 4095);
         send_word(CMD_SAMPLE, c, 1'b1, 0);
      end
      for (int c = 0; c < 8; c++) send_word(CMD_READ, c, 1'b0, 0);
   endtask

   task automatic test_breakpoints();
      int raw;
      for (int i = 1; i < 16; i++) begin
         // raw values around each segment edge of the scaled value
         raw = (BREAK_PT[i] * 4096 + 999) / 1000;
         send_word(CMD_SAMPLE, i % 4, 1'b1, raw);
         send_word(CMD_SAMPLE, i % 4, 1'b1, raw > 0 ? raw - 5 : 0);
      end
      for (int c = 0; c < 4; c++) send_word(CMD_READ, c, 1'b1, 0);
   endtask

   task automatic test_random(input int count, input logic [5:0] m, input bit calm);
      int ch;
      write_mask(m);
      no_idle = calm;
      for (int k = 0; k < count; k++) begin
         ch = ($urandom_range(9) == 0) ? $urandom_range(7, 6) : $urandom_range(5);
         if ($urandom_range(99) < 30)
            send_word(CMD_READ, ch, 1'($urandom), $urandom_range(4095));
         else
            send_word(CMD_SAMPLE, ch, $urandom_range(9) != 0, $urandom_range(4095));
      end
      no_idle = 1'b0;
   endtask

   initial begin
      mask_model = '0;
      foreach (hist_model[c, i]) hist_model[c][i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_extremes();
      test_breakpoints();
      test_random(130, 6'h3F, 1'b0);
      test_random(130, 6'($urandom), 1'b1);
      test_random(130, 6'h15, 1'b0);
      test_random(130, 6'h2A, 1'b0);
      test_random(130, 6'h3F, 1'b0);
      test_random(20, 6'h00, 1'b0);
      drain();
      $display("Covered %0d samples and %0d reads over several channel masks, %0d results.",
               n_samples, n_reads, n_results);
      if (mismatches == 0 && mean_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, mean_q.size());
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("timeout");
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
rtl/acm_pkg.sv
rtl/acm_div.sv
rtl/acm_ctrl.sv
rtl/acm_dp.sv
rtl/adc_calibrated_trimmed_mean_core.sv
test/tb_adc_calibrated_trimmed_mean_core.sv
